@@ hw/rtl/assert_macros.svh @@
// Assertion macros of the DXT1 decoder, included by dxt1_block_decoder.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DXT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DXT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/dxt1_pkg.sv @@
// Types, codes and helper functions of the DXT1 block decoder.
// No dependencies; used by dxt1_seq, dxt1_color_pipe and dxt1_block_decoder.
package dxt1_pkg;

	typedef logic [7:0] chan_t;
	typedef chan_t [2:0] rgb_t;

	localparam int RED   = 2;
	localparam int GREEN = 1;
	localparam int BLUE  = 0;

	localparam logic [1:0] CODE_E0  = 2'd0;
	localparam logic [1:0] CODE_E1  = 2'd1;
	localparam logic [1:0] CODE_MID = 2'd2;
	localparam logic [1:0] CODE_LOW = 2'd3;

	localparam logic [3:0] LAST_IDX = 4'd15;

	// floor(x / 3) == (x * 683) >> 11 for every x up to 3 * 248.
	localparam logic [19:0] DIV3_MUL = 20'd683;
	localparam int          DIV3_SHIFT = 11;

	typedef enum logic [1:0] {
		OP_PASS,
		OP_DIV2,
		OP_DIV3
	} op_t;

	// One pixel request from the sequencer to the color pipeline.
	typedef struct packed {
		rgb_t       e0;
		rgb_t       e1;
		logic       four;
		logic [1:0] code;
		logic [3:0] idx;
	} pix_req_t;

	// RGB565 to RGB888 by a plain left shift, no bit replication.
	function automatic rgb_t widen565(input logic [15:0] c);
		rgb_t w;
		w[RED]   = {c[15:11], 3'b000};
		w[GREEN] = {c[10:5], 2'b00};
		w[BLUE]  = {c[4:0], 3'b000};
		return w;
	endfunction

endpackage

@@ hw/rtl/dxt1_if.sv @@
// Handshake interfaces of the DXT1 decoder: block input and pixel output.
// No dependencies.
interface dxt1_blk_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_data;

	modport source(output valid, output block_data, input ready);
	modport sink(input valid, input block_data, output ready);
endinterface

interface dxt1_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [1:0] pixel_col;
	logic [1:0] pixel_row;
	logic       last_pixel;

	modport source(output valid, output red, output green, output blue,
		output pixel_col, output pixel_row, output last_pixel, input ready);
	modport sink(input valid, input red, input green, input blue,
		input pixel_col, input pixel_row, input last_pixel, output ready);
endinterface

@@ hw/rtl/dxt1_seq.sv @@
// Block register and pixel sequencer: holds one block and issues its 16 pixels.
// Depends on dxt1_pkg and dxt1_blk_if.
module dxt1_seq (
	input  logic              clk,
	input  logic              arst_n,
	dxt1_blk_if.sink          blk,
	output logic              req_valid,
	input  logic              req_ready,
	output dxt1_pkg::pix_req_t req
);

	logic                busy_q;
	logic [3:0]          cnt_q;
	logic [31:0]         codes_q;
	dxt1_pkg::rgb_t      e0_q;
	dxt1_pkg::rgb_t      e1_q;
	logic                four_q;
	logic                req_fire;
	logic                blk_fire;
	logic                on_last;

	assign req_fire = req_valid && req_ready;
	assign on_last  = (cnt_q == dxt1_pkg::LAST_IDX);
	// A new block loads in the same cycle the last pixel of the current one leaves.
	assign blk.ready = !busy_q || (on_last && req_ready);
	assign blk_fire  = blk.valid && blk.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (blk_fire) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (req_fire) begin
				if (on_last) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (blk_fire) begin
			e0_q    <= dxt1_pkg::widen565(blk.block_data[15:0]);
			e1_q    <= dxt1_pkg::widen565(blk.block_data[31:16]);
			four_q  <= (blk.block_data[15:0] > blk.block_data[31:16]);
			codes_q <= blk.block_data[63:32];
		end else if (req_fire) begin
			codes_q <= {2'b00, codes_q[31:2]};
		end
	end

	assign req_valid = busy_q;
	assign req.e0    = e0_q;
	assign req.e1    = e1_q;
	assign req.four  = four_q;
	assign req.code  = codes_q[1:0];
	assign req.idx   = cnt_q;

endmodule

@@ hw/rtl/dxt1_color_pipe.sv @@
// Three-stage color pipeline: operand select, divide-by-constant, output register.
// Depends on dxt1_pkg and dxt1_pix_if.
module dxt1_color_pipe (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  dxt1_pkg::pix_req_t req,
	dxt1_pix_if.source         pix
);

	logic                 v_s1, v_s2, v_s3;
	logic                 adv1, adv2, adv3;
	logic [2:0][9:0]      sum_d, sum_s1;
	dxt1_pkg::op_t        op_d, op_s1;
	logic [3:0]           idx_s1, idx_s2, idx_s3;
	logic [2:0][18:0]     val_d, val_s2;
	dxt1_pkg::rgb_t       rgb_d, rgb_s3;

	// Stall chain: a stage moves when it is empty or the stage after it moves.
	assign adv3      = !v_s3 || pix.ready;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign req_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= req_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// Stage 1: pick the endpoint sum that the code asks for.
	always_comb begin
		op_d = dxt1_pkg::OP_PASS;
		for (int ch = 0; ch < 3; ch++) begin
			sum_d[ch] = '0;
		end
		case (req.code)
			dxt1_pkg::CODE_E0: begin
				op_d = dxt1_pkg::OP_PASS;
				for (int ch = 0; ch < 3; ch++) sum_d[ch] = {2'b00, req.e0[ch]};
			end
			dxt1_pkg::CODE_E1: begin
				op_d = dxt1_pkg::OP_PASS;
				for (int ch = 0; ch < 3; ch++) sum_d[ch] = {2'b00, req.e1[ch]};
			end
			dxt1_pkg::CODE_MID: begin
				if (req.four) begin
					op_d = dxt1_pkg::OP_DIV3;
					for (int ch = 0; ch < 3; ch++)
						sum_d[ch] = {1'b0, req.e0[ch], 1'b0} + {2'b00, req.e1[ch]};
				end else begin
					op_d = dxt1_pkg::OP_DIV2;
					for (int ch = 0; ch < 3; ch++)
						sum_d[ch] = {2'b00, req.e0[ch]} + {2'b00, req.e1[ch]};
				end
			end
			default: begin
				if (req.four) begin
					op_d = dxt1_pkg::OP_DIV3;
					for (int ch = 0; ch < 3; ch++)
						sum_d[ch] = {2'b00, req.e0[ch]} + {1'b0, req.e1[ch], 1'b0};
				end else begin
					// Three-color mode: the last code is black.
					op_d = dxt1_pkg::OP_PASS;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			sum_s1 <= sum_d;
			op_s1  <= op_d;
			idx_s1 <= req.idx;
		end
	end

	// Stage 2: every result is formed as a fixed-point value with 11 fraction bits.
	always_comb begin
		logic [19:0] prod;
		for (int ch = 0; ch < 3; ch++) begin
			prod = 20'(sum_s1[ch]) * dxt1_pkg::DIV3_MUL;
			case (op_s1)
				dxt1_pkg::OP_DIV3: val_d[ch] = prod[18:0];
				dxt1_pkg::OP_DIV2: val_d[ch] = {sum_s1[ch][8:1], 11'd0};
				default:           val_d[ch] = {sum_s1[ch][7:0], 11'd0};
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			val_s2 <= val_d;
			idx_s2 <= idx_s1;
		end
	end

	// Stage 3: drop the fraction bits into the output register.
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			rgb_d[ch] = val_s2[ch][18:dxt1_pkg::DIV3_SHIFT];
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			rgb_s3 <= rgb_d;
			idx_s3 <= idx_s2;
		end
	end

	assign pix.valid      = v_s3;
	assign pix.red        = rgb_s3[dxt1_pkg::RED];
	assign pix.green      = rgb_s3[dxt1_pkg::GREEN];
	assign pix.blue       = rgb_s3[dxt1_pkg::BLUE];
	assign pix.pixel_col  = idx_s3[1:0];
	assign pix.pixel_row  = idx_s3[3:2];
	assign pix.last_pixel = (idx_s3 == dxt1_pkg::LAST_IDX);

endmodule

@@ hw/rtl/dxt1_block_decoder.sv @@
// Channel  Direction  Payload
// blk      in         block_data[63:0]: color0, color1, sixteen 2-bit codes
// pix      out        red, green, blue, pixel_col, pixel_row, last_pixel
//
// One block yields sixteen pixel results, one per cycle while pix does not stall;
// the sequencer issues one pixel per cycle and takes the next block as the last
// pixel of the current one leaves it. After a block is accepted, its first pixel
// passes the endpoint-sum, quotient and output registers before it is offered on pix.
// arst_n clears all valid bits and the sequencer; payload registers are not reset.
// A stall on pix holds full stages that cannot move on; nothing is lost or repeated.
//
// Top level of the DXT1 decoder; depends on dxt1_pkg, dxt1_if, dxt1_seq,
// dxt1_color_pipe and assert_macros.svh.
`include "assert_macros.svh"

module dxt1_block_decoder (
	input  logic       clk,
	input  logic       arst_n,
	dxt1_blk_if.sink   blk,
	dxt1_pix_if.source pix
);

	// The sequencer holds the block and issues one pixel request per cycle while
	// the color pipeline is ready for it. The pipeline registers the selected endpoint
	// sum, then the fixed-point quotient, then the final color in the output register.
	logic               req_valid;
	logic               req_ready;
	dxt1_pkg::pix_req_t req;

	dxt1_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk       (blk),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req)
	);

	dxt1_color_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.pix       (pix)
	);

	// A freshly accepted block starts at its first pixel.
	`DXT_ASSERT_NXT(a_blk_starts_at_zero, blk.valid && blk.ready, req_valid && req.idx == 4'd0, "accepted block does not start at pixel zero")
	// Pixels of one block are issued in order with no gaps in the index.
	`DXT_ASSERT_NXT(a_idx_steps, req_valid && req_ready && req.idx != dxt1_pkg::LAST_IDX, req_valid && req.idx == $past(req.idx) + 4'd1, "pixel index skipped or repeated")
	// No new block is taken while the current one is mid-way.
	`DXT_ASSERT_IMP(a_no_early_load, req_valid && req.idx != dxt1_pkg::LAST_IDX, !blk.ready, "block input ready while a block is in progress")

endmodule
